/* sv/gpr_pkg.sv */
// Shared types, constants and small arithmetic helpers for the Gaussian pyramid reduce block.
// No dependencies; compiled first.
package gpr_pkg;

  localparam int NUM_CH     = 3;   // channels per pixel
  localparam int TAPS       = 5;   // binomial kernel length
  localparam int RING       = 4;   // previous rows kept per column in the line memory
  localparam int IN_W       = 16;
  localparam int OUT_W      = 24;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 11;
  localparam int FW_W       = 12;  // frame_width register
  localparam int FH_W       = 13;  // frame_height register
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_CHANNELS = 2'd2
  } cfg_reg_e;

  // Reduced outputs released along one axis by one input position:
  // cnt outputs, the first centered d0 positions behind the current one.
  typedef struct packed {
    logic [1:0] cnt;
    logic [1:0] d0;
  } axis_t;

  typedef struct packed {
    logic [COL_W-1:0] col0;
    logic [ROW_W-1:0] row0;
    axis_t            ex;
    axis_t            ey;
    logic [2:0]       xlim;   // min(x,4): oldest usable column tap
    logic [2:0]       ylim;   // min(y,4): oldest usable row tap
    logic             x_last;
    logic             y_last;
  } item_ctl_t;

  function automatic axis_t axis_emit(input logic at_last, input logic p_even,
                                      input logic p_ge2);
    axis_t e;
    e.cnt = 2'd0;
    e.d0  = 2'd2;
    if (!at_last) begin
      if (p_even && p_ge2) e.cnt = 2'd1;
    end else if (!p_even) begin
      // even extent: one output centered one behind
      e.cnt = 2'd1;
      e.d0  = 2'd1;
    end else if (p_ge2) begin
      e.cnt = 2'd2;
    end else begin
      e.cnt = 2'd1;
      e.d0  = 2'd0;
    end
    return e;
  endfunction

  // Tap t (offset t-2 from the center) as a distance back from the newest sample,
  // replicated at both borders.
  function automatic logic [2:0] tap_idx(input logic [1:0] d, input int t,
                                         input logic [2:0] lim);
    int k;
    k = int'(d) + 2 - t;
    if (k < 0) k = 0;
    if (k > int'(lim)) k = int'(lim);
    return k[2:0];
  endfunction

  function automatic logic [31:0] binom5(input logic [31:0] e0, input logic [31:0] e1,
                                         input logic [31:0] e2, input logic [31:0] e3,
                                         input logic [31:0] e4);
    return e0 + (e1 << 2) + (e2 << 2) + (e2 << 1) + (e3 << 2) + e4;
  endfunction

endpackage

/* sv/gpr_if.sv */
// Stream interfaces for pixel input and reduced pixel output.
// Depends on gpr_pkg.
interface gpr_in_if;
  import gpr_pkg::*;
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] sample_a;
  logic [IN_W-1:0] sample_b;
  logic [IN_W-1:0] sample_c;

  modport source(output valid, output sample_a, output sample_b, output sample_c,
                 input ready);
  modport sink(input valid, input sample_a, input sample_b, input sample_c,
               output ready);
endinterface

interface gpr_out_if;
  import gpr_pkg::*;
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic [OUT_W-1:0] out_a;
  logic [OUT_W-1:0] out_b;
  logic [OUT_W-1:0] out_c;
  logic             row_end;
  logic             frame_end;

  modport source(output valid, output out_col, output out_row, output out_a,
                 output out_b, output out_c, output row_end, output frame_end,
                 input ready);
  modport sink(input valid, input out_col, input out_row, input out_a,
               input out_b, input out_c, input row_end, input frame_end,
               output ready);
endinterface

/* sv/gaussian_pyramid_reduce_top.sv */
// Channel   | dir | handshake           | payload
// px_in     | in  | valid/ready         | sample_a, sample_b, sample_c
// px_out    | out | valid/ready         | out_col, out_row, out_a/b/c, row_end, frame_end
// cfg       | in  | cfg_we_i, no ready  | cfg_idx_i, cfg_data_i
//
// One pixel request per cycle when nothing stalls. A pixel releasing n reduced pixels (n up
// to 4, at the right and bottom borders) holds px_in while the output sequencer hands out
// one result per cycle while px_out is ready. Requests pass the read, window and output registers.
// The line memory needs no clearing after reset; border taps are replicated in logic.
// A stall on px_out backs up through the sequencer and the memory stage to px_in.ready.
// Depends on gpr_pkg, gpr_if, gpr_line_buf, gpr_vfilt, gpr_hseq.
module gaussian_pyramid_reduce_top #(
  parameter int MAX_WIDTH   = 2048,
  parameter int MAX_HEIGHT  = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  gpr_in_if.sink                           px_in,
  gpr_out_if.source                        px_out,
  input  logic                             cfg_we_i,
  input  logic [gpr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gpr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import gpr_pkg::*;

  localparam int          XW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int          YW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int          VW         = SAMPLE_BITS + 4;
  localparam logic [31:0] W_RST      = ((MAX_WIDTH < 2048) ? MAX_WIDTH : 2048) - 1;
  localparam logic [31:0] H_RST      = ((MAX_HEIGHT < 2048) ? MAX_HEIGHT : 2048) - 1;
  localparam logic [XW-1:0] X_ONE    = XW'(1);
  localparam logic [YW-1:0] Y_ONE    = YW'(1);

  logic [XW-1:0] wlast_q;
  logic [YW-1:0] hlast_q;
  logic          three_q;
  logic [31:0]   w_req, h_req, w_lim, h_lim;
  logic          cfg_hit;

  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic          x_last, y_last;
  logic          accept;
  logic          take;
  logic          s1_valid_q, s1_valid_d;
  logic          s1_adv;
  item_ctl_t     ctl_d, ctl_q;
  logic [31:0]   x32, y32, col_t32, row_t32;

  logic [NUM_CH-1:0][SAMPLE_BITS-1:0]            pix;
  logic [TAPS-1:0][NUM_CH-1:0][SAMPLE_BITS-1:0]  taps;
  logic [TAPS-1:0][NUM_CH-1:0][VW-1:0]           win_a, win_b;

  // ---- configuration: keep the last valid position, saturated to the array sizes, and the channel mode
  always_comb begin
    w_req = 32'(cfg_data_i[FW_W-1:0]);
    h_req = 32'(cfg_data_i[FH_W-1:0]);
    if (w_req == 32'd0) w_lim = 32'd0;
    else if (w_req > MAX_WIDTH) w_lim = MAX_WIDTH - 1;
    else w_lim = w_req - 32'd1;
    if (h_req == 32'd0) h_lim = 32'd0;
    else if (h_req > MAX_HEIGHT) h_lim = MAX_HEIGHT - 1;
    else h_lim = h_req - 32'd1;
  end

  assign cfg_hit = cfg_we_i && (cfg_idx_i == CFG_WIDTH || cfg_idx_i == CFG_HEIGHT ||
                                cfg_idx_i == CFG_CHANNELS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q <= W_RST[XW-1:0];
      hlast_q <= H_RST[YW-1:0];
      three_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:    wlast_q <= w_lim[XW-1:0];
        CFG_HEIGHT:   hlast_q <= h_lim[YW-1:0];
        CFG_CHANNELS: three_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---- raster position
  assign s1_adv        = !s1_valid_q || take;
  assign px_in.ready   = s1_adv;
  assign accept        = px_in.valid && s1_adv;
  assign x_last        = (x_q == wlast_q);
  assign y_last        = (y_q == hlast_q);

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (cfg_hit) begin
      x_d = '0;
      y_d = '0;
    end else if (accept) begin
      if (x_last) begin
        x_d = '0;
        y_d = y_last ? '0 : y_q + Y_ONE;
      end else begin
        x_d = x_q + X_ONE;
      end
    end
  end

  // ---- per-pixel control for the later stages
  always_comb begin
    x32          = 32'(x_q);
    y32          = 32'(y_q);
    ctl_d.ex     = axis_emit(x_last, ~x_q[0], x32 >= 32'd2);
    ctl_d.ey     = axis_emit(y_last, ~y_q[0], y32 >= 32'd2);
    col_t32      = x32 - 32'(ctl_d.ex.d0);
    row_t32      = y32 - 32'(ctl_d.ey.d0);
    ctl_d.col0   = col_t32[COL_W:1];
    ctl_d.row0   = row_t32[ROW_W:1];
    ctl_d.xlim   = (x32 > 32'd4) ? 3'd4 : x32[2:0];
    ctl_d.ylim   = (y32 > 32'd4) ? 3'd4 : y32[2:0];
    ctl_d.x_last = x_last;
    ctl_d.y_last = y_last;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) s1_valid_d = 1'b1;
    else if (take) s1_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q        <= '0;
      y_q        <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      x_q        <= x_d;
      y_q        <= y_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) ctl_q <= ctl_d;
  end

  assign pix[0] = px_in.sample_a[SAMPLE_BITS-1:0];
  assign pix[1] = px_in.sample_b[SAMPLE_BITS-1:0];
  assign pix[2] = px_in.sample_c[SAMPLE_BITS-1:0];

  gpr_line_buf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_line_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_en_i(accept),
    .addr_i (x_q),
    .pix_i  (pix),
    .wb_en_i(s1_valid_q && take),
    .taps_o (taps)
  );

  gpr_vfilt #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_vfilt (
    .clk_i  (clk_i),
    .taps_i (taps),
    .dy_i   (ctl_q.ey.d0),
    .ylim_i (ctl_q.ylim),
    .shift_i(s1_valid_q && take),
    .win_a_o(win_a),
    .win_b_o(win_b)
  );

  gpr_hseq #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_hseq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ld_i      (s1_valid_q && take),
    .ctl_i     (ctl_q),
    .three_ch_i(three_q),
    .win_a_i   (win_a),
    .win_b_i   (win_b),
    .take_o    (take),
    .px_out    (px_out)
  );

endmodule

/* sv/gpr_line_buf.sv */
// Column-organized line memory: each word holds the four previous rows of one column.
// Read-modify-write per pixel with same-address forwarding. Depends on gpr_pkg.
module gpr_line_buf #(
  parameter int  MAX_WIDTH   = 2048,
  parameter int  SAMPLE_BITS = 16,
  localparam int XW          = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   rd_en_i,
  input  logic [XW-1:0]                                          addr_i,
  input  logic [gpr_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0]            pix_i,
  input  logic                                                   wb_en_i,
  output logic [gpr_pkg::TAPS-1:0][gpr_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0] taps_o
);
  import gpr_pkg::*;

  typedef logic [NUM_CH-1:0][SAMPLE_BITS-1:0]           pix_t;
  typedef logic [RING-1:0][NUM_CH-1:0][SAMPLE_BITS-1:0] col_t;

  col_t          mem [MAX_WIDTH];
  col_t          rd_q;
  col_t          fwd_data_q;
  col_t          col;
  col_t          wb_word;
  pix_t          pix_q;
  logic [XW-1:0] addr_q;
  logic          fwd_q;

  // width-one frames hit the same word every pixel
  assign col = fwd_q ? fwd_data_q : rd_q;

  always_comb begin
    wb_word[0] = pix_q;
    for (int r = 1; r < RING; r++) wb_word[r] = col[r-1];
  end

  always_comb begin
    taps_o[0] = pix_q;
    for (int r = 0; r < RING; r++) taps_o[r+1] = col[r];
  end

  always_ff @(posedge clk_i) begin
    if (wb_en_i) mem[addr_q] <= wb_word;
    if (rd_en_i) begin
      rd_q       <= mem[addr_i];
      pix_q      <= pix_i;
      addr_q     <= addr_i;
      fwd_data_q <= wb_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wb_en_i && (addr_i == addr_q);
    end
  end

endmodule

/* sv/gpr_vfilt.sv */
// Vertical binomial pass over one column and the five-column window of vertical sums.
// Two row centers are kept for the bottom border. Depends on gpr_pkg.
module gpr_vfilt #(
  parameter int  SAMPLE_BITS = 16,
  localparam int VW          = SAMPLE_BITS + 4
) (
  input  logic                                                         clk_i,
  input  logic [gpr_pkg::TAPS-1:0][gpr_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0] taps_i,
  input  logic [1:0]                                                   dy_i,
  input  logic [2:0]                                                   ylim_i,
  input  logic                                                         shift_i,
  output logic [gpr_pkg::TAPS-1:0][gpr_pkg::NUM_CH-1:0][VW-1:0]        win_a_o,
  output logic [gpr_pkg::TAPS-1:0][gpr_pkg::NUM_CH-1:0][VW-1:0]        win_b_o
);
  import gpr_pkg::*;

  logic [2:0]                         ka [TAPS];
  logic [2:0]                         kb [TAPS];
  logic [NUM_CH-1:0][VW-1:0]          va;
  logic [NUM_CH-1:0][VW-1:0]          vb;
  logic [TAPS-1:0][NUM_CH-1:0][VW-1:0] win_a_q;
  logic [TAPS-1:0][NUM_CH-1:0][VW-1:0] win_b_q;

  // second center is always the current row
  always_comb begin
    logic [31:0] sum_a;
    logic [31:0] sum_b;
    for (int t = 0; t < TAPS; t++) begin
      ka[t] = tap_idx(dy_i, t, ylim_i);
      kb[t] = tap_idx(2'd0, t, ylim_i);
    end
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_a  = binom5(32'(taps_i[ka[0]][ch]), 32'(taps_i[ka[1]][ch]),
                      32'(taps_i[ka[2]][ch]), 32'(taps_i[ka[3]][ch]),
                      32'(taps_i[ka[4]][ch]));
      sum_b  = binom5(32'(taps_i[kb[0]][ch]), 32'(taps_i[kb[1]][ch]),
                      32'(taps_i[kb[2]][ch]), 32'(taps_i[kb[3]][ch]),
                      32'(taps_i[kb[4]][ch]));
      va[ch] = sum_a[VW-1:0];
      vb[ch] = sum_b[VW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      win_a_q[0] <= va;
      win_b_q[0] <= vb;
      for (int t = 1; t < TAPS; t++) begin
        win_a_q[t] <= win_a_q[t-1];
        win_b_q[t] <= win_b_q[t-1];
      end
    end
  end

  assign win_a_o = win_a_q;
  assign win_b_o = win_b_q;

endmodule

/* sv/gpr_hseq.sv */
// Output sequencer: walks the reduced pixels an input releases (up to four), applies the
// horizontal binomial pass on the window and holds the output register. Depends on gpr_pkg.
module gpr_hseq #(
  parameter int  SAMPLE_BITS = 16,
  localparam int VW          = SAMPLE_BITS + 4
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  ld_i,
  input  gpr_pkg::item_ctl_t                                    ctl_i,
  input  logic                                                  three_ch_i,
  input  logic [gpr_pkg::TAPS-1:0][gpr_pkg::NUM_CH-1:0][VW-1:0] win_a_i,
  input  logic [gpr_pkg::TAPS-1:0][gpr_pkg::NUM_CH-1:0][VW-1:0] win_b_i,
  output logic                                                  take_o,
  gpr_out_if.source                                             px_out
);
  import gpr_pkg::*;

  item_ctl_t                          ctl_q;
  logic                               s2_valid_q, s2_valid_d;
  logic                               a_q, a_d;
  logic                               b_q, b_d;
  logic                               out_valid_q, out_valid_d;
  logic                               has_out, a_last, b_last, out_free, fire, done;
  logic [1:0]                         dx;
  logic [2:0]                         kx [TAPS];
  logic [TAPS-1:0][NUM_CH-1:0][VW-1:0] win;
  logic [NUM_CH-1:0][OUT_W-1:0]       acc;
  logic [COL_W-1:0]                   col_q;
  logic [ROW_W-1:0]                   row_q;
  logic [NUM_CH-1:0][OUT_W-1:0]       chan_q;
  logic                               re_q, fe_q;
  logic                               row_end;

  assign has_out  = s2_valid_q && (ctl_q.ex.cnt != 2'd0) && (ctl_q.ey.cnt != 2'd0);
  assign a_last   = (ctl_q.ex.cnt != 2'd2) || a_q;
  assign b_last   = (ctl_q.ey.cnt != 2'd2) || b_q;
  assign out_free = !out_valid_q || px_out.ready;
  assign fire     = has_out && out_free;
  assign done     = s2_valid_q && (!has_out || (fire && a_last && b_last));
  assign take_o   = !s2_valid_q || done;

  always_comb begin
    s2_valid_d = s2_valid_q;
    a_d        = a_q;
    b_d        = b_q;
    if (take_o) begin
      s2_valid_d = ld_i;
      a_d        = 1'b0;
      b_d        = 1'b0;
    end else if (fire) begin
      if (a_last) begin
        a_d = 1'b0;
        b_d = 1'b1;
      end else begin
        a_d = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) out_valid_d = 1'b1;
    else if (px_out.ready) out_valid_d = 1'b0;
  end

  // second column output is centered on the current column
  assign dx  = a_q ? 2'd0 : ctl_q.ex.d0;
  assign win = b_q ? win_b_i : win_a_i;

  always_comb begin
    logic [31:0] sum;
    for (int t = 0; t < TAPS; t++) kx[t] = tap_idx(dx, t, ctl_q.xlim);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum     = binom5(32'(win[kx[0]][ch]), 32'(win[kx[1]][ch]), 32'(win[kx[2]][ch]),
                       32'(win[kx[3]][ch]), 32'(win[kx[4]][ch]));
      acc[ch] = (ch == 0 || three_ch_i) ? sum[OUT_W-1:0] : '0;
    end
  end

  assign row_end = ctl_q.x_last && a_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      a_q         <= 1'b0;
      b_q         <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      a_q         <= a_d;
      b_q         <= b_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) ctl_q <= ctl_i;
    if (fire) begin
      col_q  <= ctl_q.col0 + {{(COL_W-1){1'b0}}, a_q};
      row_q  <= ctl_q.row0 + {{(ROW_W-1){1'b0}}, b_q};
      chan_q <= acc;
      re_q   <= row_end;
      fe_q   <= row_end && ctl_q.y_last && b_last;
    end
  end

  assign px_out.valid     = out_valid_q;
  assign px_out.out_col   = col_q;
  assign px_out.out_row   = row_q;
  assign px_out.out_a     = chan_q[0];
  assign px_out.out_b     = chan_q[1];
  assign px_out.out_c     = chan_q[2];
  assign px_out.row_end   = re_q;
  assign px_out.frame_end = fe_q;

endmodule
